// ----- design/swm_pkg.sv -----
// Shared types, constants and defaults for the sliding window median filter.
`default_nettype none

package swm_pkg;

  localparam int WINDOW_MAX_DEF   = 64;
  localparam int SAMPLE_WIDTH_DEF = 32;

  localparam int WIN_SIZE_W       = 7;
  localparam logic [WIN_SIZE_W-1:0] WIN_SIZE_RESET = 7'd3;

  localparam int APB_ADDR_W = 2;
  localparam int APB_DATA_W = 32;

  typedef enum logic [1:0] {
    S_IDLE,
    S_REMOVE,
    S_INSERT,
    S_EMIT
  } swm_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic remove;
    logic insert;
    logic finish;
  } swm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic out_busy;
  } swm_status_t;

endpackage

`default_nettype wire

// ----- design/sliding_window_median.sv -----
// Sliding window median filter: top level with APB register port.
// An accepted sample's median reaches the output register through the load, remove,
// insert and emit states. A new sample is taken only after the previous one has had
// its ring read, separate remove and insert passes through the sorted cell row and
// the output register load; later while a result waits.
// Reset (synchronous): window empties, window_size returns to 3, output goes invalid;
// the ring and the cell row are not cleared and need no clearing pass.
`default_nettype none

module sliding_window_median #(
  parameter int WINDOW_MAX   = swm_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           sample_valid,
  output logic                                sample_ready,
  input  wire logic signed [SAMPLE_WIDTH-1:0] sample,
  input  wire logic                           last_sample,
  output logic                                median_valid,
  input  wire logic                           median_ready,
  output logic signed [SAMPLE_WIDTH-1:0]      median,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [swm_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [swm_pkg::APB_DATA_W-1:0] pwdata,
  output logic [swm_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                pready
);

  swm_pkg::swm_cmd_t                cmd;
  swm_pkg::swm_status_t             status;
  logic                             cfg_we;
  logic [swm_pkg::WIN_SIZE_W-1:0]   win_size;

  // window_size is the only register; paddr is not decoded, so every address reaches it
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && (paddr == paddr);
  assign prdata = swm_pkg::APB_DATA_W'(win_size);

  swm_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .status       (status),
    .cmd          (cmd)
  );

  swm_datapath #(
    .WINDOW_MAX   (WINDOW_MAX),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .sample       (sample),
    .last_sample  (last_sample),
    .cfg_we       (cfg_we),
    .cfg_wdata    (pwdata[swm_pkg::WIN_SIZE_W-1:0]),
    .win_size     (win_size),
    .median       (median),
    .median_valid (median_valid),
    .median_ready (median_ready)
  );

endmodule

`default_nettype wire

// ----- design/swm_ctrl.sv -----
// Sequencer for one transaction: load, remove oldest once the window is full, insert newest, emit.
`default_nettype none

module swm_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                sample_valid,
  output logic                     sample_ready,
  input  wire swm_pkg::swm_status_t status,
  output swm_pkg::swm_cmd_t        cmd
);

  swm_pkg::swm_state_t state;
  swm_pkg::swm_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= swm_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    sample_ready = 1'b0;
    cmd          = '0;
    case (state)
      swm_pkg::S_IDLE: begin
        sample_ready = 1'b1;
        if (sample_valid) begin
          cmd.load   = 1'b1;
          state_next = swm_pkg::S_REMOVE;
        end
      end
      swm_pkg::S_REMOVE: begin
        // drop the departing sample only once the window is full
        cmd.remove = status.full;
        state_next = swm_pkg::S_INSERT;
      end
      swm_pkg::S_INSERT: begin
        cmd.insert = 1'b1;
        state_next = swm_pkg::S_EMIT;
      end
      swm_pkg::S_EMIT: begin
        // hold while an earlier result still waits in the output register and a new one is due
        if (!(status.full && status.out_busy)) begin
          cmd.finish = 1'b1;
          state_next = swm_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = swm_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- design/swm_datapath.sv -----
// Datapath: history ring, sorted cell row, window register and output register.
`default_nettype none

module swm_datapath #(
  parameter int WINDOW_MAX   = swm_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire swm_pkg::swm_cmd_t              cmd,
  output swm_pkg::swm_status_t                status,
  input  wire logic signed [SAMPLE_WIDTH-1:0] sample,
  input  wire logic                           last_sample,
  input  wire logic                           cfg_we,
  input  wire logic [swm_pkg::WIN_SIZE_W-1:0] cfg_wdata,
  output logic [swm_pkg::WIN_SIZE_W-1:0]      win_size,
  output logic signed [SAMPLE_WIDTH-1:0]      median,
  output logic                                median_valid,
  input  wire logic                           median_ready
);

  localparam int CNT_W = $clog2(WINDOW_MAX + 1);
  localparam int PTR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int EW    = (CNT_W > swm_pkg::WIN_SIZE_W) ? CNT_W : swm_pkg::WIN_SIZE_W;
  localparam int SUM_W = CNT_W + 1;

  function automatic logic [CNT_W-1:0] clamp_window(
    input logic [swm_pkg::WIN_SIZE_W-1:0] ws
  );
    logic [EW-1:0] wide;
    wide = EW'(ws);
    if (ws == '0) begin
      return CNT_W'(1);
    end
    if (wide > EW'(WINDOW_MAX)) begin
      return CNT_W'(WINDOW_MAX);
    end
    return CNT_W'(wide);
  endfunction

  logic [CNT_W-1:0]               win_eff;
  logic [CNT_W-1:0]               fill;
  logic [PTR_W-1:0]               ptr;
  logic [PTR_W-1:0]               ptr_next;
  logic [PTR_W-1:0]               old_slot;
  logic [SUM_W-1:0]               slot_sum;
  logic [PTR_W-1:0]               med_idx;
  logic [CNT_W-1:0]               win_less;
  logic signed [SAMPLE_WIDTH-1:0] cur_sample;
  logic                           cur_last;
  logic signed [SAMPLE_WIDTH-1:0] old_val;
  logic signed [SAMPLE_WIDTH-1:0] ring [WINDOW_MAX];
  logic signed [SAMPLE_WIDTH-1:0] cells [WINDOW_MAX];
  logic signed [SAMPLE_WIDTH-1:0] rem_next [WINDOW_MAX];
  logic signed [SAMPLE_WIDTH-1:0] ins_next [WINDOW_MAX];
  logic [WINDOW_MAX-1:0]          le;
  logic                           full;
  logic                           clear;

  assign full            = (fill >= win_eff);
  assign status.full     = full;
  assign status.out_busy = median_valid && !median_ready;
  assign clear           = cfg_we || (cmd.finish && cur_last);

  // slot written win_eff transactions ago, modulo the ring depth
  assign slot_sum = SUM_W'(ptr) - SUM_W'(win_eff)
                  + ((SUM_W'(ptr) < SUM_W'(win_eff)) ? SUM_W'(WINDOW_MAX) : '0);
  assign old_slot = PTR_W'(slot_sum);
  assign ptr_next = (ptr == PTR_W'(WINDOW_MAX - 1)) ? '0 : ptr + PTR_W'(1);
  assign win_less = win_eff - CNT_W'(1);
  assign med_idx  = PTR_W'(win_less >> 1);

  // each cell looks only at itself and its neighbours
  for (genvar k = 0; k < WINDOW_MAX; k++) begin : g_cell
    assign le[k] = (CNT_W'(k) < fill) && (cells[k] <= cur_sample);

    if (k == WINDOW_MAX - 1) begin : g_tail
      assign rem_next[k] = cells[k];
    end else begin : g_body
      assign rem_next[k] = (cells[k] < old_val) ? cells[k] : cells[k+1];
    end

    if (k == 0) begin : g_head
      assign ins_next[k] = le[k] ? cells[k] : cur_sample;
    end else begin : g_rest
      assign ins_next[k] = le[k] ? cells[k] : (le[k-1] ? cur_sample : cells[k-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.remove) begin
      cells <= rem_next;
    end else if (cmd.insert) begin
      cells <= ins_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      old_val    <= ring[old_slot];
      cur_sample <= sample;
      cur_last   <= last_sample;
    end
    if (cmd.insert) begin
      ring[ptr] <= cur_sample;
    end
    if (cmd.finish && full) begin
      median <= cells[med_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_size <= swm_pkg::WIN_SIZE_RESET;
      win_eff  <= clamp_window(swm_pkg::WIN_SIZE_RESET);
    end else if (cfg_we) begin
      win_size <= cfg_wdata;
      win_eff  <= clamp_window(cfg_wdata);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      ptr  <= '0;
    end else if (clear) begin
      fill <= '0;
      ptr  <= '0;
    end else if (cmd.remove) begin
      fill <= fill - CNT_W'(1);
    end else if (cmd.insert) begin
      fill <= fill + CNT_W'(1);
      ptr  <= ptr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      median_valid <= 1'b0;
    end else if (cmd.finish && full) begin
      median_valid <= 1'b1;
    end else if (median_ready) begin
      median_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ----- design/swm_checker.sv -----
// Port-level checks for the sliding window median filter, bound to the top level.
`default_nettype none

module swm_checker #(
  parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           sample_valid,
  input wire logic                           sample_ready,
  input wire logic                           median_valid,
  input wire logic                           median_ready,
  input wire logic signed [SAMPLE_WIDTH-1:0] median,
  input wire logic                           psel,
  input wire logic                           penable,
  input wire logic                           pwrite,
  input wire logic [swm_pkg::APB_DATA_W-1:0] pwdata,
  input wire logic [swm_pkg::APB_DATA_W-1:0] prdata
);

  localparam int WS_W = swm_pkg::WIN_SIZE_W;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    median_valid && !median_ready |=> median_valid && $stable(median))
    else $error("median changed or dropped while stalled");

  // one transaction at a time: ready drops after an accepted sample
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready |=> !sample_ready)
    else $error("sample accepted while previous transaction in flight");

  // a fresh result follows an accepted sample through load, remove, insert and emit
  a_result_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(median_valid) |-> $past(sample_valid && sample_ready, 4))
    else $error("result appeared without a matching transaction");

  // window_size reads back what was written
  a_cfg_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite |=> prdata[WS_W-1:0] == $past(pwdata[WS_W-1:0]))
    else $error("window_size readback mismatch");

endmodule

bind sliding_window_median swm_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_swm_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample_valid),
  .sample_ready (sample_ready),
  .median_valid (median_valid),
  .median_ready (median_ready),
  .median       (median),
  .psel         (psel),
  .penable      (penable),
  .pwrite       (pwrite),
  .pwdata       (pwdata),
  .prdata       (prdata)
);

`default_nettype wire

// ----- tb/sliding_window_median_tb.sv -----
// Self-checking testbench for the sliding window median filter.
`default_nettype none

module sliding_window_median_tb;

  localparam int SW = swm_pkg::SAMPLE_WIDTH_DEF;
  localparam int WMAX = swm_pkg::WINDOW_MAX_DEF;
  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 12;
  localparam int MAX_PRINTS = 40;
  localparam logic [swm_pkg::APB_ADDR_W-1:0] ADDR_WINDOW_SIZE = '0;

  typedef logic signed [SW-1:0] sample_t;
  typedef struct {
    sample_t value;
    logic    last;
  } sample_item_t;

  localparam sample_t SMP_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam sample_t SMP_MAX = {1'b0, {(SW-1){1'b1}}};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic sample_valid = 1'b0;
  logic sample_ready;
  sample_t sample = '0;
  logic last_sample = 1'b0;
  logic median_valid;
  logic median_ready = 1'b0;
  sample_t median;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [swm_pkg::APB_ADDR_W-1:0] paddr = '0;
  logic [swm_pkg::APB_DATA_W-1:0] pwdata = '0;
  logic [swm_pkg::APB_DATA_W-1:0] prdata;
  logic pready;

  sliding_window_median DUT (
    .clk(clk), .rst(rst),
    .sample_valid(sample_valid), .sample_ready(sample_ready),
    .sample(sample), .last_sample(last_sample),
    .median_valid(median_valid), .median_ready(median_ready), .median(median),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  // stimulus and expectations
  sample_item_t pending[$];
  sample_t expected_medians[$];
  int pushed_cnt = 0;
  int taken_cnt = 0;
  int err_cnt = 0;
  int cycle_cnt = 0;
  int send_idle = 0;
  int recv_stall = 0;
  int hold_reqs = 0;
  int hold_done = 0;
  int hold_left = 0;
  logic in_fire = 1'b0;

  // predictor state
  localparam int WIN_W = swm_pkg::WIN_SIZE_W;
  logic [WIN_W-1:0] win_reg;
  sample_t win_sorted[$];
  sample_t ring_mem[WMAX];
  logic [$clog2(WMAX)-1:0] ring_ptr;

  task automatic report_mismatch(input string msg);
    if (err_cnt < MAX_PRINTS)
      $display("MISMATCH @%0d: %s", cycle_cnt, msg);
    err_cnt++;
  endtask

  function automatic int eff_window(input logic [WIN_W-1:0] w);
    if (w == 0)
      return 1;
    if (int'(w) > WMAX)
      return WMAX;
    return int'(w);
  endfunction

  function automatic void clear_window();
    win_sorted.delete();
    ring_ptr = '0;
  endfunction

  // Slide one sample through the window and queue the median it yields.
  function automatic void slide_window(input sample_t s, input logic last);
    int w;
    int old_slot;
    int pos;
    int i;
    logic found;
    w = eff_window(win_reg);
    if (win_sorted.size() >= w) begin
      old_slot = (int'(ring_ptr) + WMAX - w) % WMAX;
      found = 1'b0;
      for (i = 0; i < win_sorted.size() && !found; i++) begin
        if (win_sorted[i] == ring_mem[old_slot]) begin
          win_sorted.delete(i);
          found = 1'b1;
        end
      end
    end
    pos = win_sorted.size();
    while (pos > 0 && win_sorted[pos-1] > s)
      pos--;
    win_sorted.insert(pos, s);
    ring_mem[ring_ptr] = s;
    ring_ptr = ring_ptr + 1'b1;
    if (win_sorted.size() >= w)
      expected_medians.push_back(win_sorted[(w + 1) / 2 - 1]);
    if (last)
      clear_window();
  endfunction

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("sliding_window_median_tb: done, errors");
      $finish;
    end
  end

  // monitor: check results, predict on accepted samples, track register traffic
  always @(posedge clk) begin
    sample_t exp_med;
    if (rst) begin
      win_reg = swm_pkg::WIN_SIZE_RESET;
      clear_window();
      in_fire = 1'b0;
    end else begin
      if (median_valid && median_ready) begin
        if (expected_medians.size() == 0) begin
          report_mismatch($sformatf("median %0d with none pending", median));
        end else begin
          exp_med = expected_medians.pop_front();
          if (median !== exp_med)
            report_mismatch($sformatf("median %0d, expected %0d", median, exp_med));
        end
      end
      in_fire = sample_valid && sample_ready;
      if (in_fire) begin
        slide_window(sample, last_sample);
        taken_cnt++;
      end
      if (psel && penable && pready && paddr == ADDR_WINDOW_SIZE) begin
        if (pwrite) begin
          win_reg = pwdata[WIN_W-1:0];
          clear_window();
        end else if (prdata[WIN_W-1:0] !== win_reg) begin
          report_mismatch($sformatf("window_size read %0d, expected %0d",
                                    prdata[WIN_W-1:0], win_reg));
        end
      end
    end
  end

  // driver: offer the next pending sample, holding it until it is accepted
  always @(negedge clk) begin
    sample_item_t it;
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (!sample_valid || in_fire) begin
      if (pending.size() != 0 && $urandom_range(99) >= send_idle) begin
        it = pending.pop_front();
        sample <= it.value;
        last_sample <= it.last;
        sample_valid <= 1'b1;
      end else begin
        sample_valid <= 1'b0;
      end
    end
  end

  // receiver: random back-pressure plus the occasional long hold-off
  always @(negedge clk) begin
    if (hold_done != hold_reqs) begin
      hold_left = HOLD_CYCLES;
      hold_done++;
    end
    if (hold_left > 0) begin
      hold_left--;
      median_ready <= 1'b0;
    end else begin
      median_ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  task automatic push_sample(input sample_t v, input logic last);
    sample_item_t it;
    it.value = v;
    it.last = last;
    pending.push_back(it);
    pushed_cnt++;
  endtask

  function automatic sample_t rand_sample();
    case ($urandom_range(9))
      0: return SMP_MIN;
      1: return SMP_MAX;
      2, 3: return sample_t'($signed($urandom_range(6)) - 3);
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Mostly whole sequences long enough to fill the window, some cut short.
  task automatic gen_stream(input int n, input int w);
    int left;
    int len;
    int k;
    logic end_flag;
    left = n;
    while (left > 0) begin
      if ($urandom_range(9) < 2)
        len = $urandom_range(w, 1);
      else
        len = $urandom_range(w + ((w < 8) ? 12 : 30), w);
      if (len > left)
        len = left;
      end_flag = ($urandom_range(9) != 0);
      for (k = 0; k < len; k++)
        push_sample(rand_sample(), (k == len - 1) && end_flag);
      left -= len;
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (taken_cnt != pushed_cnt || expected_medians.size() != 0)
      @(negedge clk);
  endtask

  task automatic settle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [swm_pkg::APB_DATA_W-1:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= ADDR_WINDOW_SIZE;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready)
      @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic run_phase(input logic [WIN_W-1:0] wval, input int idle_s,
                           input int idle_r, input int n, input logic pause_mid,
                           input logic long_hold);
    logic [swm_pkg::APB_DATA_W-1:0] wdata;
    settle();
    // random upper bits: only the low field is the register
    wdata = $urandom;
    wdata[WIN_W-1:0] = wval;
    apb_access(1'b1, wdata);
    apb_access(1'b0, '0);
    @(posedge clk);
    send_idle = idle_s;
    recv_stall = idle_r;
    if (long_hold)
      hold_reqs++;
    if (pause_mid) begin
      gen_stream(n / 2, eff_window(wval));
      wait_drained();
      gen_stream(n - n / 2, eff_window(wval));
    end else begin
      gen_stream(n, eff_window(wval));
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // directed: reset window of three, extremes, duplicates, early last
    push_sample(SMP_MIN, 1'b0);
    push_sample(SMP_MAX, 1'b0);
    push_sample('0, 1'b0);
    push_sample(-1, 1'b0);
    push_sample(1, 1'b0);
    push_sample(SMP_MIN, 1'b0);
    push_sample(SMP_MIN, 1'b0);
    push_sample(5, 1'b0);
    push_sample(5, 1'b0);
    push_sample(5, 1'b1);
    push_sample(7, 1'b0);
    push_sample(-7, 1'b1);
    push_sample(SMP_MAX, 1'b0);
    push_sample(SMP_MAX, 1'b0);
    push_sample(-1, 1'b0);
    push_sample(SMP_MIN, 1'b1);

    run_phase(7'd1, 0, 0, 40, 1'b0, 1'b0);
    run_phase(7'd0, 63, 0, 40, 1'b0, 1'b0);
    run_phase(7'd2, 0, 63, 50, 1'b0, 1'b0);
    run_phase(7'd4, 24, 24, 60, 1'b0, 1'b0);
    run_phase(7'd5, 0, 0, 60, 1'b0, 1'b1);
    run_phase(7'd64, 63, 0, 130, 1'b0, 1'b0);
    run_phase(7'd127, 0, 0, 80, 1'b0, 1'b0);
    run_phase(7'd100, 24, 24, 70, 1'b0, 1'b0);
    run_phase(7'd7, 0, 63, 60, 1'b1, 1'b0);
    run_phase(WIN_W'($urandom_range(16, 1)), 24, 24, 60, 1'b0, 1'b0);
    run_phase(7'd3, 63, 0, 50, 1'b0, 1'b0);

    wait_drained();
    repeat (20) @(negedge clk);
    if (expected_medians.size() != 0)
      report_mismatch($sformatf("%0d medians never arrived", expected_medians.size()));
    if (err_cnt == 0)
      $display("sliding_window_median_tb: done, clean");
    else
      $display("sliding_window_median_tb: done, errors");
    $finish;
  end

endmodule

`default_nettype wire
